@@ src/sbam_pkg.sv @@
// Shared widths, register map and reset values of the stretch blit address mapper.
`default_nettype none

package sbam_pkg;

  // Field widths
  localparam int unsigned POS_W      = 12;   // canvas coordinates, rows, columns, offsets
  localparam int unsigned DIM_W      = 13;   // sizes and strides
  localparam int unsigned SCL_W      = 27;   // scaled corner coordinate (quotient width)
  localparam int unsigned PROD2_W    = 25;   // row * rect_h and col * rect_w
  localparam int unsigned IDX_W      = 24;   // source index and pixel offset
  localparam int unsigned FB_W       = 26;   // framebuffer byte offset
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;

  // Size limit of a reported destination dimension
  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned DIM_FIELD_MAX = (1 << DIM_W) - 1;

  // Register reset values
  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] CANVAS_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] CANVAS_HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] SHOWN_WIDTH_RST   = DIM_W'(640);
  localparam logic [DIM_W-1:0] SHOWN_HEIGHT_RST  = DIM_W'(480);
  localparam logic [POS_W-1:0] SHOWN_LEFT_RST    = '0;
  localparam logic [POS_W-1:0] SHOWN_TOP_RST     = '0;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_CANVAS_WIDTH  = 3'd1,
    REG_CANVAS_HEIGHT = 3'd2,
    REG_SHOWN_WIDTH   = 3'd3,
    REG_SHOWN_HEIGHT  = 3'd4,
    REG_SHOWN_LEFT    = 3'd5,
    REG_SHOWN_TOP     = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

@@ src/sbam_pipe_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none

module sbam_pipe_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 13,
  parameter int unsigned QUO_W = 27
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);
  import sbam_pkg::*;

  // The numerator bits above QUO_W must be below the divisor.
  logic [DEN_W-1:0] rem_r [QUO_W-1];
  logic [DEN_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] lq_r  [QUO_W];
  logic [NUM_W+DEN_W-1:0] num_ext;

  assign num_ext = {{DEN_W{1'b0}}, num};

  // Shift in one dividend bit, subtract where it fits, shift in the quotient bit.
  function automatic logic [DEN_W+QUO_W-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [QUO_W-1:0] lq,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    trial    = {rem, lq[QUO_W-1]};
    diff     = trial - {1'b0, d};
    ge       = (trial >= {1'b0, d});
    div_step = {(ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]), lq[QUO_W-2:0], ge};
  endfunction

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]       rem_in;
    logic [DEN_W-1:0]       den_in;
    logic [QUO_W-1:0]       lq_in;
    logic [DEN_W+QUO_W-1:0] step;

    if (k == 0) begin : g_first
      assign rem_in = num_ext[QUO_W +: DEN_W];
      assign lq_in  = num[QUO_W-1:0];
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lq_in  = lq_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign step = div_step(rem_in, lq_in, den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        lq_r[k] <= step[QUO_W-1:0];
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= step[DEN_W+QUO_W-1:QUO_W];
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = lq_r[QUO_W-1];

endmodule

`default_nettype wire

@@ src/stretch_blit_address_mapper_top.sv @@
// Top level of the stretch blit address mapper: register file and mapping pipeline.
// Pipeline from the accepting edge to the result on the out_ ports: one multiply
//   stage, 27 quotient stages, one size stage, 13 quotient stages, one multiply
//   stage, then the output register.
// Throughput: one item per clock; out_stall on a valid output freezes the whole pipeline at once.
// Reset: clears every valid bit and loads the register reset values; no clearing pass.
`default_nettype none

module stretch_blit_address_mapper_top #(
  parameter int unsigned MAX_DIM = sbam_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sbam_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [sbam_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [sbam_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  // Input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sbam_pkg::POS_W-1:0]       in_rect_x,
  input  wire logic [sbam_pkg::POS_W-1:0]       in_rect_y,
  input  wire logic [sbam_pkg::DIM_W-1:0]       in_rect_w,
  input  wire logic [sbam_pkg::DIM_W-1:0]       in_rect_h,
  input  wire logic [sbam_pkg::POS_W-1:0]       in_dest_row,
  input  wire logic [sbam_pkg::POS_W-1:0]       in_dest_col,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_in_range,
  output logic      [sbam_pkg::DIM_W-1:0]       out_dest_width,
  output logic      [sbam_pkg::DIM_W-1:0]       out_dest_height,
  output logic      [sbam_pkg::IDX_W-1:0]       out_source_index,
  output logic      [sbam_pkg::FB_W-1:0]        out_frame_offset
);
  import sbam_pkg::*;

  // Quotient stages of the corner scaling and of the source lookup
  localparam int unsigned Q1      = SCL_W;
  localparam int unsigned Q2      = DIM_W;
  // Valid bits ahead of the output register: multiply, Q1, size, Q2, multiply
  localparam int unsigned PIPE_D  = Q1 + Q2 + 3;
  localparam int unsigned CAP_I   = (MAX_DIM < DIM_FIELD_MAX) ? MAX_DIM : DIM_FIELD_MAX;
  localparam logic [SCL_W-1:0] DIM_CAP = SCL_W'(CAP_I);

  // Sideband that rides along the corner dividers
  typedef struct packed {
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] rh;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             pre_ok;   // rectangle and canvas both non-empty
  } sb_a_t;

  // Sideband that rides along the source dividers
  typedef struct packed {
    logic             hit;
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] dw_sat;
    logic [DIM_W-1:0] dh_sat;
    logic [IDX_W-1:0] xcol;
    logic [IDX_W-1:0] fb_prod;
  } sb_b_t;

  // ---------------------------------------------------------------------------
  // Register file. Writes must arrive only while no item is in flight; the block
  // does not enforce it. Stages that need these registers read them directly.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] scr_w_r, cnv_w_r, cnv_h_r, shw_w_r, shw_h_r;
  logic [POS_W-1:0] shw_l_r, shw_t_r;
  logic             cfg_wr;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_WIDTH_RST;
      cnv_w_r <= CANVAS_WIDTH_RST;
      cnv_h_r <= CANVAS_HEIGHT_RST;
      shw_w_r <= SHOWN_WIDTH_RST;
      shw_h_r <= SHOWN_HEIGHT_RST;
      shw_l_r <= SHOWN_LEFT_RST;
      shw_t_r <= SHOWN_TOP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCREEN_WIDTH:  scr_w_r <= pwdata[DIM_W-1:0];
        REG_CANVAS_WIDTH:  cnv_w_r <= pwdata[DIM_W-1:0];
        REG_CANVAS_HEIGHT: cnv_h_r <= pwdata[DIM_W-1:0];
        REG_SHOWN_WIDTH:   shw_w_r <= pwdata[DIM_W-1:0];
        REG_SHOWN_HEIGHT:  shw_h_r <= pwdata[DIM_W-1:0];
        REG_SHOWN_LEFT:    shw_l_r <= pwdata[POS_W-1:0];
        REG_SHOWN_TOP:     shw_t_r <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register; unmapped words read as zero
  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(scr_w_r);
      REG_CANVAS_WIDTH:  prdata = APB_DATA_W'(cnv_w_r);
      REG_CANVAS_HEIGHT: prdata = APB_DATA_W'(cnv_h_r);
      REG_SHOWN_WIDTH:   prdata = APB_DATA_W'(shw_w_r);
      REG_SHOWN_HEIGHT:  prdata = APB_DATA_W'(shw_h_r);
      REG_SHOWN_LEFT:    prdata = APB_DATA_W'(shw_l_r);
      REG_SHOWN_TOP:     prdata = APB_DATA_W'(shw_t_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. Every stage moves together; hold everything while the
  // output register carries an item that the receiver stalls.
  // ---------------------------------------------------------------------------
  logic              adv;
  logic [PIPE_D-1:0] vld_r;
  logic              out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_D-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_D-1];
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Stage A: scale both corners of the rectangle by the presented size.
  // ---------------------------------------------------------------------------
  logic [DIM_W:0]   x1_sum, y1_sum;
  logic [SCL_W-1:0] a_px0_r, a_px1_r, a_py0_r, a_py1_r;
  sb_a_t            a_sb_r;

  assign x1_sum = (DIM_W+1)'(in_rect_x) + (DIM_W+1)'(in_rect_w);
  assign y1_sum = (DIM_W+1)'(in_rect_y) + (DIM_W+1)'(in_rect_h);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px0_r       <= SCL_W'(in_rect_x) * SCL_W'(shw_w_r);
      a_px1_r       <= SCL_W'(x1_sum) * SCL_W'(shw_w_r);
      a_py0_r       <= SCL_W'(in_rect_y) * SCL_W'(shw_h_r);
      a_py1_r       <= SCL_W'(y1_sum) * SCL_W'(shw_h_r);
      a_sb_r.rw     <= in_rect_w;
      a_sb_r.rh     <= in_rect_h;
      a_sb_r.row    <= in_dest_row;
      a_sb_r.col    <= in_dest_col;
      a_sb_r.pre_ok <= (in_rect_w != '0) && (in_rect_h != '0) &&
                       (cnv_w_r != '0) && (cnv_h_r != '0);
    end
  end

  // Divide by the canvas size; a zero canvas gives garbage here, dropped by pre_ok
  logic [SCL_W-1:0] sx0, sx1, sy0, sy1;

  sbam_pipe_div #(.NUM_W(SCL_W), .DEN_W(DIM_W), .QUO_W(Q1)) u_div_x0 (
    .clk(clk), .en(adv), .num(a_px0_r), .den(cnv_w_r), .quo(sx0)
  );
  sbam_pipe_div #(.NUM_W(SCL_W), .DEN_W(DIM_W), .QUO_W(Q1)) u_div_x1 (
    .clk(clk), .en(adv), .num(a_px1_r), .den(cnv_w_r), .quo(sx1)
  );
  sbam_pipe_div #(.NUM_W(SCL_W), .DEN_W(DIM_W), .QUO_W(Q1)) u_div_y0 (
    .clk(clk), .en(adv), .num(a_py0_r), .den(cnv_h_r), .quo(sy0)
  );
  sbam_pipe_div #(.NUM_W(SCL_W), .DEN_W(DIM_W), .QUO_W(Q1)) u_div_y1 (
    .clk(clk), .en(adv), .num(a_py1_r), .den(cnv_h_r), .quo(sy1)
  );

  // Carry the item's own fields alongside the quotient stages
  sb_a_t sb1_r [Q1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1_r[0] <= a_sb_r;
      for (int k = 1; k < Q1; k++) begin
        sb1_r[k] <= sb1_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: destination size, range check, source dividends, screen position.
  // ---------------------------------------------------------------------------
  sb_a_t            sb1_o;
  logic [SCL_W-1:0] dw_full, dh_full, dw_b, dh_b;
  logic             empty_b, inside_b;

  assign sb1_o   = sb1_r[Q1-1];
  assign dw_full = sx1 - sx0;
  assign dh_full = sy1 - sy0;
  // Drop the size where the rectangle, the canvas or the scaled image is empty
  assign empty_b  = !sb1_o.pre_ok || (dw_full == '0) || (dh_full == '0);
  assign dw_b     = empty_b ? '0 : dw_full;
  assign dh_b     = empty_b ? '0 : dh_full;
  assign inside_b = !empty_b && (SCL_W'(sb1_o.row) < dh_full) &&
                    (SCL_W'(sb1_o.col) < dw_full);

  logic [SCL_W-1:0]   b_dw_r, b_dh_r;
  logic [PROD2_W-1:0] b_nr_r, b_nc_r;
  logic [IDX_W-1:0]   b_yrow_r, b_xcol_r;
  logic [DIM_W-1:0]   b_rw_r, b_dw_sat_r, b_dh_sat_r;
  logic               b_inside_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_dw_r     <= dw_b;
      b_dh_r     <= dh_b;
      b_inside_r <= inside_b;
      b_rw_r     <= sb1_o.rw;
      b_nr_r     <= PROD2_W'(sb1_o.row) * PROD2_W'(sb1_o.rh);
      b_nc_r     <= PROD2_W'(sb1_o.col) * PROD2_W'(sb1_o.rw);
      // Only the low address bits survive into the byte offset
      b_yrow_r   <= sy0[IDX_W-1:0] + IDX_W'(shw_t_r) + IDX_W'(sb1_o.row);
      b_xcol_r   <= sx0[IDX_W-1:0] + IDX_W'(shw_l_r) + IDX_W'(sb1_o.col);
      b_dw_sat_r <= (dw_b > DIM_CAP) ? DIM_CAP[DIM_W-1:0] : dw_b[DIM_W-1:0];
      b_dh_sat_r <= (dh_b > DIM_CAP) ? DIM_CAP[DIM_W-1:0] : dh_b[DIM_W-1:0];
    end
  end

  // Nearest source row and column; the quotient stays below rect_h / rect_w
  // whenever the position lies inside, otherwise the result is dropped.
  logic [DIM_W-1:0] src_row, src_col;

  sbam_pipe_div #(.NUM_W(PROD2_W), .DEN_W(SCL_W), .QUO_W(Q2)) u_div_row (
    .clk(clk), .en(adv), .num(b_nr_r), .den(b_dh_r), .quo(src_row)
  );
  sbam_pipe_div #(.NUM_W(PROD2_W), .DEN_W(SCL_W), .QUO_W(Q2)) u_div_col (
    .clk(clk), .en(adv), .num(b_nc_r), .den(b_dw_r), .quo(src_col)
  );

  // Row stride multiply enters the first sideband stage
  sb_b_t sb2_r [Q2];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2_r[0].hit     <= b_inside_r;
      sb2_r[0].rw      <= b_rw_r;
      sb2_r[0].dw_sat  <= b_dw_sat_r;
      sb2_r[0].dh_sat  <= b_dh_sat_r;
      sb2_r[0].xcol    <= b_xcol_r;
      sb2_r[0].fb_prod <= b_yrow_r * IDX_W'(scr_w_r);
      for (int k = 1; k < Q2; k++) begin
        sb2_r[k] <= sb2_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: source row times rectangle width, pixel offset sum.
  // ---------------------------------------------------------------------------
  sb_b_t            sb2_o;
  logic [IDX_W-1:0] e_rowp_r, e_fb_r;
  logic [DIM_W-1:0] e_col_r, e_dw_sat_r, e_dh_sat_r;
  logic             e_inside_r;

  assign sb2_o = sb2_r[Q2-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_rowp_r   <= IDX_W'(src_row) * IDX_W'(sb2_o.rw);
      e_col_r    <= src_col;
      e_fb_r     <= sb2_o.fb_prod + sb2_o.xcol;
      e_inside_r <= sb2_o.hit;
      e_dw_sat_r <= sb2_o.dw_sat;
      e_dh_sat_r <= sb2_o.dh_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: zero the addresses of a position outside the rectangle.
  // ---------------------------------------------------------------------------
  logic             out_in_range_r;
  logic [DIM_W-1:0] out_dest_width_r, out_dest_height_r;
  logic [IDX_W-1:0] out_source_index_r;
  logic [FB_W-1:0]  out_frame_offset_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_in_range_r     <= e_inside_r;
      out_dest_width_r   <= e_dw_sat_r;
      out_dest_height_r  <= e_dh_sat_r;
      out_source_index_r <= e_inside_r ? (e_rowp_r + IDX_W'(e_col_r)) : '0;
      out_frame_offset_r <= e_inside_r ? {e_fb_r, 2'b00} : '0;
    end
  end

  assign out_in_range     = out_in_range_r;
  assign out_dest_width   = out_dest_width_r;
  assign out_dest_height  = out_dest_height_r;
  assign out_source_index = out_source_index_r;
  assign out_frame_offset = out_frame_offset_r;

endmodule

`default_nettype wire

@@ src/sbam_checker.sv @@
// Port-level checks of the stretch blit address mapper and their bind.
`default_nettype none

module sbam_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_in_range,
  input wire logic [sbam_pkg::DIM_W-1:0] out_dest_width,
  input wire logic [sbam_pkg::DIM_W-1:0] out_dest_height,
  input wire logic [sbam_pkg::IDX_W-1:0] out_source_index,
  input wire logic [sbam_pkg::FB_W-1:0]  out_frame_offset
);
  import sbam_pkg::*;

  // A stalled item stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_in_range) && $stable(out_dest_width) &&
      $stable(out_dest_height) && $stable(out_source_index) && $stable(out_frame_offset))
    else $error("stalled item changed");

  // Back-pressure comes only from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

  // A position inside needs a non-empty destination
  a_range_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |-> out_dest_width != '0 && out_dest_height != '0)
    else $error("in range on an empty destination");

  // Outside positions carry no addresses
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_source_index == '0 && out_frame_offset == '0)
    else $error("addresses on a position outside");

endmodule

bind stretch_blit_address_mapper_top sbam_checker u_sbam_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_in_range     (out_in_range),
  .out_dest_width   (out_dest_width),
  .out_dest_height  (out_dest_height),
  .out_source_index (out_source_index),
  .out_frame_offset (out_frame_offset)
);

`default_nettype wire
